@@ hdl/msu_pkg.sv @@
// shared types and constants for the min tracking stack
// no dependencies; used by min_tracking_stack_unit
`timescale 1ns / 1ps

package msu_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DEPTH_WIDTH     = 7;
    localparam int ACTION_WIDTH    = 2;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

endpackage

@@ hdl/msu_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module msu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/min_tracking_stack_unit.sv @@
// min tracking stack top level: control, top-of-stack registers, result register
// depends on msu_pkg and msu_ram
`timescale 1ns / 1ps

// Bounded LIFO stack of signed values that reports the minimum of its contents
// with every beat. Each stored entry keeps its value and the running minimum of
// itself and everything below it, in two rams; the top entry is also held in
// registers. Push, query, clear and a pop that empties the stack or finds it
// empty take the direct path: the result is registered in the cycle after the
// input beat, and the next input beat is taken in the same cycle the result beat
// is taken. A pop that leaves entries behind passes the fetch state, as the new
// top entry comes from the registered ram read. No clearing pass follows reset.
module min_tracking_stack_unit #(
    parameter int STACK_DEPTH = msu_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = msu_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [msu_pkg::ACTION_WIDTH-1:0]    action,
    input  logic signed [VALUE_WIDTH-1:0]       push_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [VALUE_WIDTH-1:0]       popped_value,
    output logic signed [VALUE_WIDTH-1:0]       current_minimum,
    output logic [msu_pkg::DEPTH_WIDTH-1:0]     depth,
    output logic                                is_empty,
    output logic                                op_error
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    msu_pkg::state_t state_reg, state_next;
    msu_pkg::action_t act;

    logic [CW-1:0]                count_reg, count_next;
    logic signed [VALUE_WIDTH-1:0] top_val_reg, top_val_next;
    logic signed [VALUE_WIDTH-1:0] top_min_reg, top_min_next;
    logic signed [VALUE_WIDTH-1:0] popped_reg, popped_next;
    logic                          err_reg, err_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          in_acc;
    logic                          full;
    logic                          empty;
    logic                          deep_pop;
    logic signed [VALUE_WIDTH-1:0] push_min;
    logic [CW-1:0]                 pop_idx;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;
    logic [VALUE_WIDTH-1:0]        rd_val;
    logic [VALUE_WIDTH-1:0]        rd_min;

    assign act      = msu_pkg::action_t'(action);
    assign in_acc   = in_valid && in_ready;
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign empty    = (count_reg == '0);
    assign deep_pop = (count_reg >= CW'(2));
    assign pop_idx  = count_reg - CW'(2);
    assign push_min = (empty || (push_value < top_min_reg)) ? push_value : top_min_reg;

    msu_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (push_value),
        .rd_addr (ram_raddr),
        .rd_data (rd_val)
    );

    msu_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_min_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (push_min),
        .rd_addr (ram_raddr),
        .rd_data (rd_min)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msu_pkg::ST_IDLE:
            begin
                if (in_acc && (act == msu_pkg::ACT_POP) && deep_pop)
                begin
                    state_next = msu_pkg::ST_FETCH;
                end
            end
            msu_pkg::ST_FETCH:
            begin
                state_next = msu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = msu_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = (state_reg == msu_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
        ram_we    = in_acc && (act == msu_pkg::ACT_PUSH) && !full;
        ram_waddr = count_reg[AW-1:0];
        ram_raddr = pop_idx[AW-1:0];
    end

    // datapath
    always_comb
    begin
        count_next     = count_reg;
        top_val_next   = top_val_reg;
        top_min_next   = top_min_reg;
        popped_next    = popped_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (state_reg == msu_pkg::ST_FETCH)
        begin
            top_val_next   = rd_val;
            top_min_next   = rd_min;
            out_valid_next = 1'b1;
        end
        else if (in_acc)
        begin
            popped_next    = '0;
            err_next       = 1'b0;
            out_valid_next = 1'b1;
            case (act)
                msu_pkg::ACT_PUSH:
                begin
                    if (full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        count_next   = count_reg + CW'(1);
                        top_val_next = push_value;
                        top_min_next = push_min;
                    end
                end
                msu_pkg::ACT_POP:
                begin
                    if (empty)
                    begin
                        popped_next = '1;
                        err_next    = 1'b1;
                    end
                    else
                    begin
                        count_next     = count_reg - CW'(1);
                        popped_next    = top_val_reg;
                        out_valid_next = !deep_pop;
                    end
                end
                msu_pkg::ACT_QUERY:
                begin
                    err_next = empty;
                end
                msu_pkg::ACT_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msu_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
        popped_reg  <= popped_next;
        err_reg     <= err_next;
    end

    assign out_valid       = out_valid_reg;
    assign popped_value    = popped_reg;
    assign current_minimum = empty ? '0 : top_min_reg;
    assign depth           = msu_pkg::DEPTH_WIDTH'(count_reg);
    assign is_empty        = empty;
    assign op_error        = err_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_fetch_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msu_pkg::ST_FETCH) |-> !out_valid_reg)
        else $error("result pending while new top is fetched");

    a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msu_pkg::ST_FETCH) |=> (state_reg == msu_pkg::ST_IDLE) && out_valid_reg)
        else $error("fetch did not deliver a result");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (act == msu_pkg::ACT_PUSH) && !full)
            |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow the stack");

    a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (act == msu_pkg::ACT_POP) && (count_reg == CW'(1)))
            |=> out_valid_reg && empty && (popped_reg == $past(top_val_reg)))
        else $error("pop of last entry returned wrong value");

endmodule
